// ===== rtl/hsp_pkg.sv =====
package hsp_pkg;

	localparam int KIND_BITS     = 3;
	localparam int INDEX_BITS    = 6;
	localparam int POSITION_BITS = 17;
	localparam int COUNT_BITS    = 7;

	typedef enum logic [2:0] {
		K_ADD      = 3'd0,
		K_SET      = 3'd1,
		K_REMOVE   = 3'd2,
		K_CLEAR    = 3'd3,
		K_READ     = 3'd4,
		K_EVAL_GLB = 3'd5,
		K_EVAL_SEG = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Work the back end has to do for one request.
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_WRITE = 3'd1,
		OP_SHIFT = 3'd2,
		OP_READ  = 3'd3,
		OP_EVAL  = 3'd4
	} op_t;

	typedef struct packed {
		op_t     op;
		status_t status;
		logic    s_first;
		logic    s_last;
	} cmd_ctl_t;

endpackage

// ===== rtl/hsp_ram.sv =====
module hsp_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/hsp_queue.sv =====
module hsp_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	// Two entries: enough for the front end to classify the next request
	// while the back end is busy.
	logic [WIDTH-1:0] ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rdata   = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/hsp_front.sv =====
module hsp_front #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 32,
	parameter int FRACTION_BITS = 16,
	localparam int AW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic [hsp_pkg::KIND_BITS-1:0]        kind,
	input  logic [hsp_pkg::INDEX_BITS-1:0]       point_index,
	input  logic [3*COORD_BITS-1:0]              in_xyz,
	input  logic [hsp_pkg::POSITION_BITS-1:0]    position,
	input  logic                                 q_full,
	output logic                                 q_push,
	output hsp_pkg::cmd_ctl_t                    cmd_ctl,
	output logic [AW-1:0]                        cmd_addr,
	output logic [CW-1:0]                        cmd_cnt,
	output logic [CW-1:0]                        cmd_new_cnt,
	output logic [3*COORD_BITS-1:0]              cmd_xyz,
	output logic [FRACTION_BITS-1:0]             cmd_t
);

	import hsp_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int IW = ((CW > INDEX_BITS) ? CW : INDEX_BITS) + 1;
	localparam int TW = (POSITION_BITS > F + 1) ? POSITION_BITS : F + 1;
	localparam int GW = F + 1 + CW;
	localparam logic [TW-1:0] ONE_T = TW'(1) << F;

	logic [CW-1:0]  cnt_q;
	kind_t          kd;
	logic [IW-1:0]  idx_w;
	logic [IW-1:0]  n_w;
	logic [TW-1:0]  pos_w;
	logic           pos_one;
	logic [F:0]     pc;
	logic [GW-1:0]  glb_prod;
	logic [CW-1:0]  seg_sel;
	logic           tone_sel;
	logic [F-1:0]   tf_sel;
	logic [CW:0]    seg1;
	logic           seg_end;
	op_t            ev_op;
	logic [AW-1:0]  ev_addr;

	assign full    = q_full;
	assign q_push  = push && !q_full;
	assign cmd_xyz = in_xyz;
	assign cmd_cnt = cnt_q;

	always_comb begin
		kd       = kind_t'(kind);
		idx_w    = IW'(point_index);
		n_w      = IW'(cnt_q);
		pos_w    = TW'(position);
		pos_one  = pos_w >= ONE_T;
		pc       = pos_one ? {1'b1, {F{1'b0}}} : pos_w[F:0];
		glb_prod = GW'(pc) * GW'(cnt_q - CW'(1));

		// A global position splits into a segment number and a fraction.
		seg_sel  = (kd == K_EVAL_GLB) ? glb_prod[F +: CW] : CW'(point_index);
		tone_sel = (kd == K_EVAL_SEG) && pos_one;
		tf_sel   = (kd == K_EVAL_GLB) ? glb_prod[F-1:0] : pos_w[F-1:0];
		seg1     = (CW+1)'(seg_sel) + (CW+1)'(1);
		seg_end  = seg1 >= (CW+1)'(cnt_q);

		// The ends of a segment and the last segment return a stored point.
		if (seg_end || (!tone_sel && tf_sel == '0)) begin
			ev_op   = OP_READ;
			ev_addr = AW'(seg_sel);
		end else if (tone_sel) begin
			ev_op   = OP_READ;
			ev_addr = AW'(seg1);
		end else begin
			ev_op   = OP_EVAL;
			ev_addr = AW'(seg_sel);
		end

		cmd_ctl.op      = OP_NONE;
		cmd_ctl.status  = ST_OK;
		cmd_ctl.s_first = seg_sel == '0;
		cmd_ctl.s_last  = seg1 == (CW+1)'(cnt_q) - (CW+1)'(1);
		cmd_addr        = AW'(point_index);
		cmd_new_cnt     = cnt_q;
		cmd_t           = tf_sel;

		unique case (kd) inside
			K_ADD: begin
				if (cnt_q == CW'(MAX_POINTS)) begin
					cmd_ctl.status = ST_FULL;
				end else begin
					cmd_ctl.op  = OP_WRITE;
					cmd_addr    = AW'(cnt_q);
					cmd_new_cnt = cnt_q + CW'(1);
				end
			end
			K_SET, K_REMOVE, K_READ: begin
				if (cnt_q == '0) begin
					cmd_ctl.status = ST_EMPTY;
				end else if (idx_w >= n_w) begin
					cmd_ctl.status = ST_RANGE;
				end else if (kd == K_SET) begin
					cmd_ctl.op = OP_WRITE;
				end else if (kd == K_REMOVE) begin
					cmd_ctl.op  = OP_SHIFT;
					cmd_new_cnt = cnt_q - CW'(1);
				end else begin
					cmd_ctl.op = OP_READ;
				end
			end
			K_CLEAR: begin
				cmd_new_cnt = '0;
			end
			K_EVAL_GLB: begin
				if (cnt_q == '0) begin
					cmd_ctl.status = ST_EMPTY;
				end else begin
					cmd_ctl.op = ev_op;
					cmd_addr   = ev_addr;
				end
			end
			K_EVAL_SEG: begin
				if (cnt_q == '0) begin
					cmd_ctl.status = ST_EMPTY;
				end else if (idx_w >= n_w) begin
					cmd_ctl.status = ST_RANGE;
				end else begin
					cmd_ctl.op = ev_op;
					cmd_addr   = ev_addr;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push) begin
			cnt_q <= cmd_new_cnt;
		end
	end

endmodule

// ===== rtl/hsp_back.sv =====
module hsp_back #(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 32,
	parameter int FRACTION_BITS = 16,
	localparam int AW = $clog2(MAX_POINTS),
	localparam int CW = $clog2(MAX_POINTS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_take,
	input  hsp_pkg::cmd_ctl_t             cmd_ctl,
	input  logic [AW-1:0]                 cmd_addr,
	input  logic [CW-1:0]                 cmd_cnt,
	input  logic [CW-1:0]                 cmd_new_cnt,
	input  logic [3*COORD_BITS-1:0]       cmd_xyz,
	input  logic [FRACTION_BITS-1:0]      cmd_t,
	output logic                          out_valid,
	input  logic                          out_pop,
	output logic [3*COORD_BITS-1:0]       out_xyz,
	output logic [CW-1:0]                 out_cnt,
	output hsp_pkg::status_t              out_status
);

	import hsp_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int F   = FRACTION_BITS;
	localparam int OW  = CB + 1;
	localparam int CFW = F + 4;
	localparam int PRW = CFW + OW;
	localparam int ACW = CB + F + 8;
	localparam int RW  = ACW - F - 1;
	localparam logic signed [RW-1:0] CMAX = RW'((64'd1 << (CB - 1)) - 64'd1);
	localparam logic signed [RW-1:0] CMIN = -CMAX - RW'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_WRITE, S_SH_RD, S_SH_WR, S_RD, S_RD_WAIT,
		S_FETCH, S_PREP, S_MAC, S_FIN
	} state_t;

	state_t                  state_q;
	cmd_ctl_t                ctl_q;
	logic [AW-1:0]           addr_q;
	logic [CW-1:0]           n_q;
	logic [CW-1:0]           new_cnt_q;
	logic [3*CB-1:0]         wdata_q;
	logic [F-1:0]            t_q;
	logic [F:0]              t2_q;
	logic [F:0]              t3_q;
	logic [3:0]              fj_q;
	logic [3*CB-1:0]         slot_q [8];
	logic signed [CFW-1:0]   coef_q [4];
	logic signed [OW-1:0]    opnd_q [12];
	logic [3:0]              k_q;
	logic signed [PRW-1:0]   prod_q;
	logic signed [ACW-1:0]   acc_q;
	logic [CB-1:0]           res_q [3];
	logic                    out_valid_q;

	logic                    ram_we;
	logic [3*CB-1:0]         ram_wdata;
	logic                    ram_re;
	logic [AW-1:0]           ram_raddr;
	logic [3*CB-1:0]         ram_rdata;
	logic                    sh_more;
	logic [CW:0]             fetch_a;
	logic [2*F:0]            sq;
	logic [2*F+1:0]          cu;
	logic                    closed;
	logic signed [CFW-1:0]   h [4];
	logic signed [OW-1:0]    nx_opnd [12];
	logic [3:0]              km;
	logic signed [ACW-1:0]   acc_next;
	logic signed [RW-1:0]    rnd;
	logic [CB-1:0]           sat_v;

	hsp_ram #(.WIDTH(3 * CB), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_take  = (state_q == S_IDLE) && cmd_valid;
	assign out_valid = out_valid_q;
	assign sh_more   = ((CW+1)'(addr_q) + (CW+1)'(1)) < (CW+1)'(n_q);

	// Fetch order: P0, P[n-1], P1, P[n-2], P[s-1], P[s], P[s+1], P[s+2].
	always_comb begin
		case (fj_q[2:0])
			3'd0: fetch_a = '0;
			3'd1: fetch_a = (CW+1)'(n_q) - (CW+1)'(1);
			3'd2: fetch_a = (CW+1)'(1);
			3'd3: fetch_a = (CW+1)'(n_q) - (CW+1)'(2);
			3'd4: fetch_a = ctl_q.s_first ? '0 : (CW+1)'(addr_q) - (CW+1)'(1);
			3'd5: fetch_a = (CW+1)'(addr_q);
			3'd6: fetch_a = (CW+1)'(addr_q) + (CW+1)'(1);
			default: fetch_a = ctl_q.s_last ? (CW+1)'(n_q) - (CW+1)'(1)
				: (CW+1)'(addr_q) + (CW+1)'(2);
		endcase
		ram_we    = (state_q == S_WRITE) || (state_q == S_SH_WR);
		ram_wdata = (state_q == S_WRITE) ? wdata_q : ram_rdata;
		ram_re    = ((state_q == S_SH_RD) && sh_more) || (state_q == S_RD)
			|| ((state_q == S_FETCH) && !fj_q[3]);
		if (state_q == S_SH_RD) begin
			ram_raddr = AW'((CW+1)'(addr_q) + (CW+1)'(1));
		end else if (state_q == S_FETCH) begin
			ram_raddr = AW'(fetch_a);
		end else begin
			ram_raddr = addr_q;
		end
	end

	// Powers of the fraction, each rounded half up.
	always_comb begin
		sq = (2*F+1)'(t_q) * (2*F+1)'(t_q) + ((2*F+1)'(1) << (F - 1));
		cu = (2*F+2)'(t2_q) * (2*F+2)'(t_q) + ((2*F+2)'(1) << (F - 1));
	end

	// Basis weights (the point terms carry the factor two) and the operands.
	always_comb begin
		logic signed [OW-1:0] p0, pn1, p1, pn2, pm1, ps, ps1, ps2;
		closed = slot_q[0] == slot_q[1];
		h[0] = CFW'(2) * (CFW'(2) * $signed({3'b0, t3_q}) - CFW'(3) * $signed({3'b0, t2_q})
			+ (CFW'(1) <<< F));
		h[1] = CFW'(2) * (CFW'(3) * $signed({3'b0, t2_q}) - CFW'(2) * $signed({3'b0, t3_q}));
		h[2] = $signed({3'b0, t3_q}) - CFW'(2) * $signed({3'b0, t2_q})
			+ $signed(CFW'(t_q));
		h[3] = $signed({3'b0, t3_q}) - $signed({3'b0, t2_q});
		for (int c = 0; c < 3; c++) begin
			p0  = OW'($signed(slot_q[0][(2-c)*CB +: CB]));
			pn1 = OW'($signed(slot_q[1][(2-c)*CB +: CB]));
			p1  = OW'($signed(slot_q[2][(2-c)*CB +: CB]));
			pn2 = OW'($signed(slot_q[3][(2-c)*CB +: CB]));
			pm1 = OW'($signed(slot_q[4][(2-c)*CB +: CB]));
			ps  = OW'($signed(slot_q[5][(2-c)*CB +: CB]));
			ps1 = OW'($signed(slot_q[6][(2-c)*CB +: CB]));
			ps2 = OW'($signed(slot_q[7][(2-c)*CB +: CB]));
			nx_opnd[4*c]     = ps;
			nx_opnd[4*c + 1] = ps1;
			if (ctl_q.s_first) begin
				nx_opnd[4*c + 2] = closed ? p1 - pn2 : p1 - p0;
			end else begin
				nx_opnd[4*c + 2] = ps1 - pm1;
			end
			if (ctl_q.s_last) begin
				nx_opnd[4*c + 3] = closed ? p1 - pn2 : pn1 - pn2;
			end else begin
				nx_opnd[4*c + 3] = ps2 - ps;
			end
		end
	end

	// Accumulate, round half up at scale 2^(F+1), saturate.
	always_comb begin
		km       = k_q - 4'd1;
		acc_next = ((km[1:0] == 2'd0) ? '0 : acc_q) + ACW'(prod_q);
		rnd      = RW'((acc_next + (ACW'(1) <<< F)) >>> (F + 1));
		if (rnd > CMAX) begin
			sat_v = CB'(CMAX);
		end else if (rnd < CMIN) begin
			sat_v = CB'(CMIN);
		end else begin
			sat_v = CB'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) begin
			ctl_q     <= cmd_ctl;
			addr_q    <= cmd_addr;
			n_q       <= cmd_cnt;
			new_cnt_q <= cmd_new_cnt;
			wdata_q   <= cmd_xyz;
			t_q       <= cmd_t;
			for (int c = 0; c < 3; c++) begin
				res_q[c] <= '0;
			end
		end
		if (state_q == S_SH_WR) begin
			addr_q <= AW'((CW+1)'(addr_q) + (CW+1)'(1));
		end
		if (state_q == S_RD_WAIT) begin
			res_q[0] <= ram_rdata[2*CB +: CB];
			res_q[1] <= ram_rdata[CB +: CB];
			res_q[2] <= ram_rdata[0 +: CB];
		end
		if (state_q == S_FETCH) begin
			if (fj_q != 4'd0) begin
				slot_q[3'(fj_q - 4'd1)] <= ram_rdata;
			end
			if (fj_q == 4'd0) begin
				t2_q <= sq[2*F:F];
			end
			if (fj_q == 4'd1) begin
				t3_q <= cu[2*F:F];
			end
		end
		if (state_q == S_PREP) begin
			coef_q <= h;
			opnd_q <= nx_opnd;
		end
		if (state_q == S_MAC) begin
			if (k_q != 4'd12) begin
				prod_q <= PRW'(coef_q[k_q[1:0]] * opnd_q[k_q]);
			end
			if (k_q != 4'd0) begin
				acc_q <= acc_next;
				if (km[1:0] == 2'd3) begin
					res_q[km[3:2]] <= sat_v;
				end
			end
		end
		if (state_q == S_FIN && (!out_valid_q || out_pop)) begin
			out_xyz    <= {res_q[0], res_q[1], res_q[2]};
			out_cnt    <= new_cnt_q;
			out_status <= ctl_q.status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fj_q        <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one being popped in the same cycle.
			if (state_q == S_FIN && (!out_valid_q || out_pop)) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						fj_q <= '0;
						unique case (cmd_ctl.op)
							OP_WRITE: state_q <= S_WRITE;
							OP_SHIFT: state_q <= S_SH_RD;
							OP_READ:  state_q <= S_RD;
							OP_EVAL:  state_q <= S_FETCH;
							default:  state_q <= S_FIN;
						endcase
					end
				end
				S_WRITE:   state_q <= S_FIN;
				S_SH_RD:   state_q <= sh_more ? S_SH_WR : S_FIN;
				S_SH_WR:   state_q <= S_SH_RD;
				S_RD:      state_q <= S_RD_WAIT;
				S_RD_WAIT: state_q <= S_FIN;
				S_FETCH: begin
					if (fj_q == 4'd8) begin
						state_q <= S_PREP;
					end else begin
						fj_q <= fj_q + 4'd1;
					end
				end
				S_PREP: begin
					k_q     <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					if (k_q == 4'd12) begin
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + 4'd1;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_pop) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/hermite_spline_point_table.sv =====
// Table of up to MAX_POINTS 3D control points with a Catmull-Rom cubic
// Hermite curve evaluator. Requests come in through push/full and each one
// produces exactly one result, taken through empty/pop in request order.
// A front end checks requests that depend on the point count against it,
// updates the count and turns global positions into a segment and a
// fraction; a two-entry queue hands the work to a back end that owns the
// point memory. The back end takes one request at a time. There, remove
// shifts each entry after the removed one down through the single memory
// read port one entry at a time, and a full curve evaluation reads eight
// points from the memory and forms twelve products through one shared
// multiplier. The next request is classified while the back end works,
// and a finished result waits in an output register while the back end
// takes on the next request, which finishes only once that result has
// been popped.
module hermite_spline_point_table #(
	parameter int MAX_POINTS    = 64,
	parameter int COORD_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [hsp_pkg::KIND_BITS-1:0]         kind,
	input  logic [hsp_pkg::INDEX_BITS-1:0]        point_index,
	input  logic signed [COORD_BITS-1:0]          in_x,
	input  logic signed [COORD_BITS-1:0]          in_y,
	input  logic signed [COORD_BITS-1:0]          in_z,
	input  logic [hsp_pkg::POSITION_BITS-1:0]     position,
	output logic                                  empty,
	input  logic                                  pop,
	output logic signed [COORD_BITS-1:0]          out_x,
	output logic signed [COORD_BITS-1:0]          out_y,
	output logic signed [COORD_BITS-1:0]          out_z,
	output logic [hsp_pkg::COUNT_BITS-1:0]        point_count,
	output logic [1:0]                            status
);

	import hsp_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int CB = COORD_BITS;
	localparam int F  = FRACTION_BITS;
	localparam int CTW = $bits(cmd_ctl_t);
	localparam int QW = CTW + AW + 2 * CW + 3 * CB + F;

	// Command fields from the front end toward the queue.
	logic              q_push;
	logic              q_full;
	cmd_ctl_t          f_ctl;
	logic [AW-1:0]     f_addr;
	logic [CW-1:0]     f_cnt;
	logic [CW-1:0]     f_new_cnt;
	logic [3*CB-1:0]   f_xyz;
	logic [F-1:0]      f_t;

	// The same fields as the back end sees them.
	logic [QW-1:0]     q_wdata;
	logic [QW-1:0]     q_rdata;
	logic              q_empty;
	logic              b_take;
	cmd_ctl_t          b_ctl;
	logic [AW-1:0]     b_addr;
	logic [CW-1:0]     b_cnt;
	logic [CW-1:0]     b_new_cnt;
	logic [3*CB-1:0]   b_xyz;
	logic [F-1:0]      b_t;

	// Result register contents.
	logic              r_valid;
	logic [3*CB-1:0]   r_xyz;
	logic [CW-1:0]     r_cnt;
	status_t           r_status;

	hsp_front #(
		.MAX_POINTS    (MAX_POINTS),
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.kind        (kind),
		.point_index (point_index),
		.in_xyz      ({in_x, in_y, in_z}),
		.position    (position),
		.q_full      (q_full),
		.q_push      (q_push),
		.cmd_ctl     (f_ctl),
		.cmd_addr    (f_addr),
		.cmd_cnt     (f_cnt),
		.cmd_new_cnt (f_new_cnt),
		.cmd_xyz     (f_xyz),
		.cmd_t       (f_t)
	);

	assign q_wdata = {f_ctl, f_addr, f_cnt, f_new_cnt, f_xyz, f_t};

	hsp_queue #(.WIDTH(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (b_take),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {b_ctl, b_addr, b_cnt, b_new_cnt, b_xyz, b_t} = q_rdata;

	hsp_back #(
		.MAX_POINTS    (MAX_POINTS),
		.COORD_BITS    (COORD_BITS),
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (!q_empty),
		.cmd_take    (b_take),
		.cmd_ctl     (b_ctl),
		.cmd_addr    (b_addr),
		.cmd_cnt     (b_cnt),
		.cmd_new_cnt (b_new_cnt),
		.cmd_xyz     (b_xyz),
		.cmd_t       (b_t),
		.out_valid   (r_valid),
		.out_pop     (pop),
		.out_xyz     (r_xyz),
		.out_cnt     (r_cnt),
		.out_status  (r_status)
	);

	// The oldest result sits on the outputs while empty is low.
	assign empty       = !r_valid;
	assign out_x       = r_xyz[2*CB +: CB];
	assign out_y       = r_xyz[CB +: CB];
	assign out_z       = r_xyz[0 +: CB];
	assign point_count = COUNT_BITS'(r_cnt);
	assign status      = r_status;

endmodule

// ===== test/tb_hermite_spline_point_table.sv =====
module tb_hermite_spline_point_table;
	import hsp_pkg::*;

	localparam int MAX_POINTS    = 64;
	localparam int COORD_BITS    = 32;
	localparam int FRACTION_BITS = 16;
	localparam longint ONE_FRAC  = longint'(1) << FRACTION_BITS;
	localparam longint HALF_FRAC = ONE_FRAC >> 1;
	localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	// Kind code 7 is not decoded by the block; it must leave the table alone.
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 200;
	localparam int HOLD_CYCLES = 300;

	typedef longint coord3_t [3];

	// One result as it appears on the output ports.
	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [COORD_BITS-1:0] z;
		logic [COUNT_BITS-1:0]        count;
		status_t                      st;
	} point_result_t;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	logic [KIND_BITS-1:0] kind;
	logic [INDEX_BITS-1:0] point_index;
	logic signed [COORD_BITS-1:0] in_x;
	logic signed [COORD_BITS-1:0] in_y;
	logic signed [COORD_BITS-1:0] in_z;
	logic [POSITION_BITS-1:0] position;
	logic empty;
	logic pop;
	logic signed [COORD_BITS-1:0] out_x;
	logic signed [COORD_BITS-1:0] out_y;
	logic signed [COORD_BITS-1:0] out_z;
	logic [COUNT_BITS-1:0] point_count;
	logic [1:0] status;

	hermite_spline_point_table #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.point_index(point_index),
		.in_x(in_x),
		.in_y(in_y),
		.in_z(in_z),
		.position(position),
		.empty(empty),
		.pop(pop),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z),
		.point_count(point_count),
		.status(status)
	);

	// Shadow copy of the point table: axis 0 is x, 1 is y, 2 is z.
	longint table_pts [3][MAX_POINTS];
	int     table_count;

	point_result_t pending_results[$];

	int  mismatches;
	int  requests_sent;
	int  results_checked;
	int  evals_sent;
	int  cycle_count;
	bit  idle_enable;
	int  hold_left;
	int  hold_requests;
	bit  results_lost;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The whole run is bounded; a hang anywhere ends in a failure.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d results outstanding",
					cycle_count, pending_results.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Long receiver hold-off, counted down here while the checker keeps pop low.
	// Each new hold request from the test sequence restarts the count.
	initial begin
		int hold_seen;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end else if (hold_left > 0) begin
				hold_left--;
			end
		end
	end

	function automatic longint clamp_coord(input longint v);
		if (v > COORD_MAX) begin
			return COORD_MAX;
		end
		if (v < COORD_MIN) begin
			return COORD_MIN;
		end
		return v;
	endfunction

	// Twice the Catmull-Rom tangent at point i. A closed curve wraps around at both
	// ends, so the first and last points share one tangent; open ends use a
	// one-sided difference.
	function automatic longint twice_tangent(input int a, input int n, input int i,
			input bit closed);
		if (i == 0) begin
			return closed ? table_pts[a][1] - table_pts[a][n-2]
				: table_pts[a][1] - table_pts[a][0];
		end
		if (i == n - 1) begin
			return closed ? table_pts[a][1] - table_pts[a][n-2]
				: table_pts[a][n-1] - table_pts[a][n-2];
		end
		return table_pts[a][i+1] - table_pts[a][i-1];
	endfunction

	// Curve point on segment s at fraction t. A fraction of zero, a fraction of one
	// or more, and the last segment all return a stored point untouched.
	function automatic void segment_point(input int s, input longint t_in,
			output coord3_t o);
		longint t;
		longint t2;
		longint t3;
		longint h [4];
		longint acc;
		int     n;
		int     e;
		bit     closed;
		n = table_count;
		t = (t_in > ONE_FRAC) ? ONE_FRAC : t_in;
		if (s + 1 >= n || t == 0 || t == ONE_FRAC) begin
			e = (s + 1 < n && t == ONE_FRAC) ? s + 1 : s;
			for (int a = 0; a < 3; a++) begin
				o[a] = table_pts[a][e];
			end
			return;
		end
		// Powers of t are rounded half up at each step, as the hardware does.
		t2 = (t * t + HALF_FRAC) >>> FRACTION_BITS;
		t3 = (t2 * t + HALF_FRAC) >>> FRACTION_BITS;
		h[0] = 2 * t3 - 3 * t2 + ONE_FRAC;
		h[1] = -2 * t3 + 3 * t2;
		h[2] = t3 - 2 * t2 + t;
		h[3] = t3 - t2;
		closed = table_pts[0][0] == table_pts[0][n-1] && table_pts[1][0] == table_pts[1][n-1]
			&& table_pts[2][0] == table_pts[2][n-1];
		for (int a = 0; a < 3; a++) begin
			acc = 2 * (h[0] * table_pts[a][s] + h[1] * table_pts[a][s+1])
				+ h[2] * twice_tangent(a, n, s, closed)
				+ h[3] * twice_tangent(a, n, s + 1, closed);
			// The sum has scale 2^(F+1); the arithmetic shift floors.
			o[a] = clamp_coord((acc + ONE_FRAC) >>> (FRACTION_BITS + 1));
		end
	endfunction

	// Applies one accepted request to the shadow table and returns its result.
	function automatic point_result_t table_update(input logic [2:0] k,
			input int idx, input longint vx, input longint vy, input longint vz,
			input longint pos_in);
		point_result_t r;
		coord3_t o;
		longint pos;
		longint f;
		o = '{0, 0, 0};
		r.st = ST_OK;
		case (k) inside
			K_ADD: begin
				if (table_count >= MAX_POINTS) begin
					r.st = ST_FULL;
				end else begin
					table_pts[0][table_count] = vx;
					table_pts[1][table_count] = vy;
					table_pts[2][table_count] = vz;
					table_count++;
				end
			end
			K_SET, K_REMOVE, K_READ: begin
				if (table_count == 0) begin
					r.st = ST_EMPTY;
				end else if (idx >= table_count) begin
					r.st = ST_RANGE;
				end else if (k == K_SET) begin
					table_pts[0][idx] = vx;
					table_pts[1][idx] = vy;
					table_pts[2][idx] = vz;
				end else if (k == K_REMOVE) begin
					for (int i = idx; i + 1 < table_count; i++) begin
						for (int a = 0; a < 3; a++) begin
							table_pts[a][i] = table_pts[a][i+1];
						end
					end
					table_count--;
				end else begin
					for (int a = 0; a < 3; a++) begin
						o[a] = table_pts[a][idx];
					end
				end
			end
			K_CLEAR: begin
				table_count = 0;
			end
			K_EVAL_GLB: begin
				if (table_count == 0) begin
					r.st = ST_EMPTY;
				end else begin
					pos = (pos_in > ONE_FRAC) ? ONE_FRAC : pos_in;
					f = pos * (table_count - 1);
					segment_point(int'(f >>> FRACTION_BITS), f & (ONE_FRAC - 1), o);
				end
			end
			K_EVAL_SEG: begin
				if (table_count == 0) begin
					r.st = ST_EMPTY;
				end else if (idx >= table_count) begin
					r.st = ST_RANGE;
				end else begin
					segment_point(idx, pos_in, o);
				end
			end
			default: begin
			end
		endcase
		r.x = o[0][COORD_BITS-1:0];
		r.y = o[1][COORD_BITS-1:0];
		r.z = o[2][COORD_BITS-1:0];
		r.count = table_count[COUNT_BITS-1:0];
		return r;
	endfunction

	// Offers one request and returns at the edge that accepts it. Push stays high
	// on return so back-to-back requests need no extra edge.
	task automatic send_request(input logic [2:0] k, input int idx,
			input logic [COORD_BITS-1:0] vx, input logic [COORD_BITS-1:0] vy,
			input logic [COORD_BITS-1:0] vz, input logic [POSITION_BITS-1:0] pos);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		push        <= 1'b1;
		kind        <= k;
		point_index <= idx[INDEX_BITS-1:0];
		in_x        <= vx;
		in_y        <= vy;
		in_z        <= vz;
		position    <= pos;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		pending_results.insert(pending_results.size(), table_update(k, idx,
			longint'(signed'(vx)), longint'(signed'(vy)), longint'(signed'(vz)),
			longint'(pos)));
		requests_sent++;
		if (k == K_EVAL_GLB || k == K_EVAL_SEG) begin
			evals_sent++;
		end
	endtask

	task automatic wait_all_results();
		push <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Checks every result popped off the block and drives pop for the next edge,
	// stalling in random bursts and during a requested hold-off.
	initial begin
		point_result_t want;
		int stall_left;
		stall_left = 0;
		mismatches = 0;
		results_checked = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Result with no request outstanding: x=%h y=%h z=%h",
							out_x, out_y, out_z);
					end
				end else begin
					want = pending_results.pop_front();
					if (out_x !== want.x || out_y !== want.y || out_z !== want.z
							|| point_count !== want.count || status !== want.st) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Mismatch on result %0d", results_checked);
							$display("  expected x=%h y=%h z=%h count=%0d status=%0d",
								want.x, want.y, want.z, want.count, want.st);
							$display("  actual   x=%h y=%h z=%h count=%0d status=%0d",
								out_x, out_y, out_z, point_count, status);
						end
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
			end else if (idle_enable && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
			pop <= (hold_left == 0 && stall_left == 0);
		end
	end

	function automatic logic [COORD_BITS-1:0] pick_coord(input int a);
		case ($urandom_range(0, 7))
			0: return COORD_MAX[COORD_BITS-1:0];
			1: return COORD_MIN[COORD_BITS-1:0];
			2, 3: return $urandom;
			// Reusing the first point makes a closed curve likely.
			4: return (table_count > 0) ? table_pts[a][0][COORD_BITS-1:0] : '0;
			default: return $urandom_range(0, 1 << 22) - (1 << 21);
		endcase
	endfunction

	function automatic logic [POSITION_BITS-1:0] pick_position();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_FRAC[POSITION_BITS-1:0];
			2: return POSITION_BITS'($urandom_range(ONE_FRAC + 1, (1 << POSITION_BITS) - 1));
			default: return POSITION_BITS'($urandom_range(0, ONE_FRAC));
		endcase
	endfunction

	function automatic int pick_index();
		if ($urandom_range(0, 5) == 0 || table_count == 0) begin
			return $urandom_range(0, (1 << INDEX_BITS) - 1);
		end
		return $urandom_range(0, table_count);
	endfunction

	task automatic send_random_request();
		logic [2:0] k;
		int w;
		w = $urandom_range(0, 99);
		if (w < ((table_count > 16) ? 10 : 30)) begin
			k = K_ADD;
		end else if (w < 40) begin
			k = K_SET;
		end else if (w < 52) begin
			k = K_REMOVE;
		end else if (w < 60) begin
			k = K_READ;
		end else if (w < 62) begin
			k = K_CLEAR;
		end else if (w < 63) begin
			k = KIND_UNUSED;
		end else if (w < 80) begin
			k = K_EVAL_GLB;
		end else begin
			k = K_EVAL_SEG;
		end
		send_request(k, pick_index(), pick_coord(0), pick_coord(1), pick_coord(2),
			pick_position());
	endtask

	// Every request kind but add on an empty table, plus the undecoded kind.
	task automatic test_empty_table();
		send_request(K_SET, 0, 1, 2, 3, 0);
		send_request(K_REMOVE, 0, 0, 0, 0, 0);
		send_request(K_READ, 63, 0, 0, 0, 0);
		send_request(K_EVAL_GLB, 0, 0, 0, 0, 32768);
		send_request(K_EVAL_SEG, 0, 0, 0, 0, 32768);
		send_request(K_CLEAR, 0, 0, 0, 0, 0);
		send_request(KIND_UNUSED, 63, '1, '1, '1, '1);
	endtask

	// Coordinate extremes, set, reads in and out of range, and a middle remove.
	task automatic test_table_edits();
		send_request(K_ADD, 0, COORD_MAX[COORD_BITS-1:0], COORD_MIN[COORD_BITS-1:0], 0, 0);
		send_request(K_ADD, 0, '1, 32'h0001_0000, 32'h8000_0001, 0);
		send_request(K_ADD, 0, 5, 6, 7, 0);
		send_request(K_SET, 1, 32'h1234_5678, 32'hfedc_ba98, 0, 0);
		send_request(K_SET, 3, 1, 1, 1, 0);
		send_request(K_READ, 1, 0, 0, 0, 0);
		send_request(K_READ, 63, 0, 0, 0, 0);
		send_request(K_REMOVE, 1, 0, 0, 0, 0);
		send_request(K_READ, 1, 0, 0, 0, 0);
		send_request(K_REMOVE, 2, 0, 0, 0, 0);
		send_request(K_CLEAR, 0, 0, 0, 0, 0);
	endtask

	// Open and closed curves, fraction end cases, last segment, global clamping
	// and an overshoot that saturates.
	task automatic test_curve_cases();
		send_request(K_ADD, 0, 0, 0, 0, 0);
		send_request(K_ADD, 0, 32'h0004_0000, 32'h0002_0000, 32'hffff_0000, 0);
		send_request(K_ADD, 0, 32'h0008_0000, 32'hfffe_0000, 32'h0003_0000, 0);
		send_request(K_ADD, 0, 32'h0010_0000, 32'h0001_8000, 32'h0000_4000, 0);
		send_request(K_EVAL_SEG, 0, 0, 0, 0, 0);
		send_request(K_EVAL_SEG, 1, 0, 0, 0, ONE_FRAC[POSITION_BITS-1:0]);
		send_request(K_EVAL_SEG, 1, 0, 0, 0, '1);
		send_request(K_EVAL_SEG, 3, 0, 0, 0, 20000);
		send_request(K_EVAL_SEG, 0, 0, 0, 0, 1);
		send_request(K_EVAL_SEG, 2, 0, 0, 0, POSITION_BITS'(ONE_FRAC - 1));
		send_request(K_EVAL_SEG, 4, 0, 0, 0, 100);
		send_request(K_EVAL_GLB, 0, 0, 0, 0, 0);
		send_request(K_EVAL_GLB, 0, 0, 0, 0, ONE_FRAC[POSITION_BITS-1:0]);
		send_request(K_EVAL_GLB, 0, 0, 0, 0, 70000);
		send_request(K_EVAL_GLB, 0, 0, 0, 0, 40000);
		// Close the curve by making the last point equal the first.
		send_request(K_SET, 3, 0, 0, 0, 0);
		send_request(K_EVAL_SEG, 0, 0, 0, 0, 30000);
		send_request(K_EVAL_SEG, 2, 0, 0, 0, 50000);
		send_request(K_CLEAR, 0, 0, 0, 0, 0);
		send_request(K_ADD, 0, 0, 0, 0, 0);
		send_request(K_ADD, 0, COORD_MAX[COORD_BITS-1:0], COORD_MIN[COORD_BITS-1:0],
			COORD_MAX[COORD_BITS-1:0], 0);
		send_request(K_ADD, 0, COORD_MAX[COORD_BITS-1:0], COORD_MIN[COORD_BITS-1:0],
			COORD_MAX[COORD_BITS-1:0], 0);
		send_request(K_ADD, 0, COORD_MIN[COORD_BITS-1:0], COORD_MAX[COORD_BITS-1:0],
			COORD_MIN[COORD_BITS-1:0], 0);
		send_request(K_EVAL_SEG, 1, 0, 0, 0, 16384);
		send_request(K_EVAL_SEG, 1, 0, 0, 0, 49152);
		send_request(K_CLEAR, 0, 0, 0, 0, 0);
	endtask

	// Fills the table, adds once more and evaluates, then removes the first entry so
	// that the whole table shifts down, and reads and removes the last entry.
	task automatic test_full_table();
		for (int i = 0; i < MAX_POINTS; i++) begin
			send_request(K_ADD, 0, $urandom, $urandom, $urandom, 0);
		end
		send_request(K_ADD, 0, 1, 2, 3, 0);
		send_request(K_EVAL_GLB, 0, 0, 0, 0,
			POSITION_BITS'($urandom_range(1, ONE_FRAC - 1)));
		send_request(K_REMOVE, 0, 0, 0, 0, 0);
		send_request(K_READ, 62, 0, 0, 0, 0);
		send_request(K_REMOVE, 62, 0, 0, 0, 0);
		send_request(K_CLEAR, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random_mix(input int n);
		for (int i = 0; i < n; i++) begin
			send_random_request();
		end
	endtask

	// Holds the receiver off long enough that the block fills and pushes back,
	// then lets the table settle before going on.
	task automatic test_backpressure();
		hold_requests++;
		for (int i = 0; i < 24; i++) begin
			send_random_request();
		end
		wait_all_results();
	endtask

	initial begin
		arst_n      = 1'b0;
		push        = 1'b0;
		kind        = '0;
		point_index = '0;
		in_x        = '0;
		in_y        = '0;
		in_z        = '0;
		position    = '0;
		table_count = 0;
		requests_sent   = 0;
		evals_sent  = 0;
		hold_requests = 0;
		results_lost = 1'b0;
		idle_enable = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_table_edits();
		test_curve_cases();
		test_full_table();
		test_backpressure();
		test_random_mix(590);
		test_backpressure();
		// The final stretch runs with no idling on either side.
		idle_enable = 1'b0;
		test_random_mix(100);

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			results_lost = 1'b1;
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("Ran %0d table requests, %0d of them curve evaluations, and checked %0d results",
			requests_sent, evals_sent, results_checked);
		$display("under random stalls and a long output hold-off; %0d mismatches", mismatches);
		if (mismatches == 0 && !results_lost) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
